// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the Q-learning update core.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QLU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qlu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QLU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qlu assertion failed");

`endif

// ===== hw/rtl/qlu_pkg.sv =====
// Shared types, constants and helpers for the Q-learning update core.
// No dependencies; imported by every module of the block except qlu_ram.
package qlu_pkg;

	localparam int unsigned STATE_BITS = 10;
	localparam int unsigned ROW_W      = 48;

	localparam logic [1:0] OP_CHOOSE = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] ACT_ZERO  = 2'd0;
	localparam logic [1:0] ACT_ONE   = 2'd1;
	localparam logic [1:0] ACT_TWO   = 2'd2;
	localparam logic [1:0] ACT_THREE = 2'd3;

	localparam logic [2:0] CFG_LEARNING_RATE = 3'd0;
	localparam logic [2:0] CFG_DISCOUNT      = 3'd1;
	localparam logic [2:0] CFG_EXPLORE       = 3'd2;
	localparam logic [2:0] CFG_MAJOR_REWARD  = 3'd3;
	localparam logic [2:0] CFG_PENALTY       = 3'd4;
	localparam logic [2:0] CFG_POSITIONS     = 3'd5;

	localparam logic [15:0] RST_LEARNING_RATE = 16'd6554;
	localparam logic [15:0] RST_DISCOUNT      = 16'd58982;
	localparam logic [9:0]  RST_EXPLORE       = 10'd100;
	localparam logic [15:0] RST_MAJOR_REWARD  = 16'h0100;
	localparam logic [15:0] RST_PENALTY       = 16'hFF00;
	localparam logic [10:0] RST_POSITIONS     = 11'd16;

	localparam logic [10:0] THOUSAND        = 11'd1000;
	localparam logic [9:0]  DRAW_FIRST_LIM  = 10'd330;
	localparam logic [9:0]  DRAW_SECOND_LIM = 10'd500;

	typedef struct packed {
		logic [15:0]        learning_rate;
		logic [15:0]        discount;
		logic [9:0]         explore_thousandths;
		logic signed [15:0] major_reward;
		logic signed [15:0] penalty;
		logic [10:0]        positions;
	} cfg_t;

	typedef struct packed {
		logic load_item;
		logic reduce;
		logic rd_old;
		logic cap_cur;
		logic cap_old;
		logic mul1;
		logic tgt;
		logic mul3;
		logic fin;
		logic clear;
		logic div_start;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       div_busy;
		logic       clear_last;
	} sts_t;

	function automatic logic signed [15:0] lane_get(input logic [ROW_W-1:0] row,
		input logic [1:0] act);
		logic signed [15:0] v;
		case (act)
			ACT_ZERO: v = row[15:0];
			ACT_ONE:  v = row[31:16];
			default:  v = row[47:32];
		endcase
		return v;
	endfunction

	function automatic logic [ROW_W-1:0] lane_set(input logic [ROW_W-1:0] row,
		input logic [1:0] act, input logic [15:0] val);
		logic [ROW_W-1:0] r;
		r = row;
		case (act)
			ACT_ZERO: r[15:0]  = val;
			ACT_ONE:  r[31:16] = val;
			default:  r[47:32] = val;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/qlu_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module qlu_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/qlu_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on qlu_pkg for the dividend width.
module qlu_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [qlu_pkg::STATE_BITS-1:0] dividend,
	input  logic [10:0]                    divisor,
	output logic                           busy,
	output logic [qlu_pkg::STATE_BITS-1:0] quotient,
	output logic [10:0]                    remainder
);
	import qlu_pkg::*;

	localparam int unsigned N  = STATE_BITS;
	localparam int unsigned CW = $clog2(N);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [N-1:0]  quo_q;
	logic [10:0]   rem_q;
	logic [10:0]   dvs_q;
	logic [11:0]   trial;
	logic [11:0]   diff;
	logic          fits;

	assign trial = {rem_q, quo_q[N-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(N - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[10:0] : trial[10:0];
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ===== hw/rtl/qlu_dp.sv =====
// Datapath: item registers, index reduction, Q table, reward divider,
// update arithmetic and result registers. Depends on qlu_pkg, qlu_ram, qlu_div.
module qlu_dp #(
	parameter int unsigned STATES = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qlu_pkg::cfg_t        cfg,
	input  qlu_pkg::cmd_t        cmd,
	output qlu_pkg::sts_t        sts,
	input  logic [1:0]           opcode,
	input  logic [1:0]           action,
	input  logic [9:0]           old_state,
	input  logic [9:0]           current_state,
	input  logic [9:0]           draw_explore,
	input  logic [9:0]           draw_first,
	input  logic [9:0]           draw_second,
	output logic [1:0]           chosen_action,
	output logic                 was_greedy,
	output logic signed [15:0]   q_value,
	output logic                 saturated
);
	import qlu_pkg::*;

	localparam int unsigned AW = $clog2(STATES);

	// item registers
	logic [1:0]        op_q;
	logic [1:0]        act_q;
	logic [9:0]        old_raw_q;
	logic [9:0]        cur_raw_q;
	logic [9:0]        dexp_q;
	logic [9:0]        dfirst_q;
	logic [9:0]        dsecond_q;
	logic [AW-1:0]     old_idx_q;
	logic [AW-1:0]     cur_idx_q;
	logic [AW-1:0]     old_red;
	logic [AW-1:0]     cur_red;

	// table and arithmetic
	logic [AW-1:0]        clr_addr_q;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [ROW_W-1:0]     ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [ROW_W-1:0]     ram_rdata;
	logic [ROW_W-1:0]     row_cur_q;
	logic [ROW_W-1:0]     row_old_q;
	logic signed [15:0]   old_lane_q;
	logic signed [32:0]   p1_q;
	logic signed [33:0]   p2_q;
	logic signed [33:0]   target_q;
	logic signed [51:0]   p3_q;
	logic signed [52:0]   acc;
	logic signed [20:0]   nv;
	logic signed [15:0]   nv_sat;
	logic                 nv_clip;
	logic signed [15:0]   r0, r1, r2;
	logic [1:0]           best;
	logic signed [15:0]   maxq;
	logic [16:0]          one_minus_alpha;
	logic signed [15:0]   reward;
	logic [10:0]          pos_eff;
	logic [9:0]           eps_eff;
	logic                 greedy;
	logic [1:0]           rand_act;
	logic                 div_busy;
	logic [9:0]           div_quo;
	logic [10:0]          div_rem;

	// capture the item; action three behaves as action two
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q      <= opcode;
			act_q     <= (action == ACT_THREE) ? ACT_TWO : action;
			old_raw_q <= old_state;
			cur_raw_q <= current_state;
			dexp_q    <= draw_explore;
			dfirst_q  <= draw_first;
			dsecond_q <= draw_second;
		end
		if (cmd.reduce) begin
			old_idx_q <= old_red;
			cur_idx_q <= cur_red;
		end
	end

	// state index modulo STATES: reciprocal multiply, registered quotient
	if (STATES < 1024) begin : g_mod
		localparam int unsigned RECIP = (1 << 20) / STATES + 1;
		logic [29:0] pc;
		logic [29:0] po;
		logic [9:0]  qcur_q;
		logic [9:0]  qold_q;
		logic [19:0] mc;
		logic [19:0] mo;
		logic [9:0]  rc;
		logic [9:0]  ro;

		assign pc = 30'(current_state) * 30'(RECIP);
		assign po = 30'(old_state) * 30'(RECIP);

		always_ff @(posedge clk) begin
			if (cmd.load_item) begin
				qcur_q <= pc[29:20];
				qold_q <= po[29:20];
			end
		end

		assign mc      = 20'(qcur_q) * 20'(STATES);
		assign mo      = 20'(qold_q) * 20'(STATES);
		assign rc      = cur_raw_q - mc[9:0];
		assign ro      = old_raw_q - mo[9:0];
		assign cur_red = AW'(rc);
		assign old_red = AW'(ro);
	end else begin : g_wide
		assign cur_red = AW'(cur_raw_q);
		assign old_red = AW'(old_raw_q);
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// row selection and best action of the current row
	assign r0 = lane_get(row_cur_q, ACT_ZERO);
	assign r1 = lane_get(row_cur_q, ACT_ONE);
	assign r2 = lane_get(row_cur_q, ACT_TWO);

	always_comb begin
		if (r0 >= r1 && r0 >= r2) begin
			best = ACT_ZERO;
		end else if (r1 >= r2) begin
			best = ACT_ONE;
		end else begin
			best = ACT_TWO;
		end
	end

	assign maxq = lane_get(row_cur_q, best);

	always_ff @(posedge clk) begin
		if (cmd.cap_cur) begin
			row_cur_q <= ram_rdata;
		end
		if (cmd.cap_old) begin
			row_old_q  <= ram_rdata;
			old_lane_q <= lane_get(ram_rdata, act_q);
		end
	end

	// update arithmetic, each product registered before it is used
	assign one_minus_alpha = 17'h10000 - {1'b0, cfg.learning_rate};
	assign pos_eff = (cfg.positions == 11'd0) ? 11'd1 : cfg.positions;
	assign reward  = (div_rem == {1'b0, div_quo}) ? cfg.major_reward : cfg.penalty;

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			p1_q <= $signed({1'b0, cfg.discount}) * maxq;
			p2_q <= $signed({1'b0, one_minus_alpha}) * old_lane_q;
		end
		if (cmd.tgt) begin
			target_q <= $signed({reward, 16'h0000}) + p1_q;
		end
		if (cmd.mul3) begin
			p3_q <= $signed({1'b0, cfg.learning_rate}) * target_q;
		end
	end

	// round to nearest, ties up, then saturate
	assign acc = $signed({p2_q, 16'h0000}) + p3_q + 53'sd2147483648;
	assign nv  = acc[52:32];

	always_comb begin
		nv_clip = 1'b1;
		if (nv > 21'sd32767) begin
			nv_sat = 16'sh7FFF;
		end else if (nv < -21'sd32768) begin
			nv_sat = -16'sh8000;
		end else begin
			nv_sat  = nv[15:0];
			nv_clip = 1'b0;
		end
	end

	// epsilon-greedy choice
	assign eps_eff  = (cfg.explore_thousandths > 10'd1000) ? 10'd1000
		: cfg.explore_thousandths;
	assign greedy   = {1'b0, dexp_q} < (THOUSAND - {1'b0, eps_eff});
	assign rand_act = (dfirst_q < DRAW_FIRST_LIM) ? ACT_ZERO
		: ((dsecond_q < DRAW_SECOND_LIM) ? ACT_ONE : ACT_TWO);

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			chosen_action <= ACT_ZERO;
			was_greedy    <= 1'b0;
			q_value       <= '0;
			saturated     <= 1'b0;
			case (op_q)
				OP_CHOOSE: begin
					chosen_action <= greedy ? best : rand_act;
					was_greedy    <= greedy;
				end
				OP_UPDATE: begin
					q_value   <= nv_sat;
					saturated <= nv_clip;
				end
				OP_READ: begin
					q_value <= lane_get(row_cur_q, act_q);
				end
				default: begin
				end
			endcase
		end
	end

	// table port muxing
	assign ram_we    = cmd.clear || (cmd.fin && op_q == OP_UPDATE);
	assign ram_waddr = cmd.clear ? clr_addr_q : old_idx_q;
	assign ram_wdata = cmd.clear ? '0 : lane_set(row_old_q, act_q, nv_sat);
	assign ram_raddr = cmd.rd_old ? old_idx_q : cur_idx_q;

	qlu_ram #(
		.WIDTH(ROW_W),
		.DEPTH(STATES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	qlu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (10'(cur_idx_q)),
		.divisor   (pos_eff),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign sts.op         = op_q;
	assign sts.div_busy   = div_busy;
	assign sts.clear_last = (clr_addr_q == AW'(STATES - 1));
endmodule

// ===== hw/rtl/qlu_ctrl.sv =====
// Controller: sequences clearing, table reads, update steps and the result.
// Depends on qlu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qlu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  qlu_pkg::sts_t sts,
	output qlu_pkg::cmd_t cmd
);
	import qlu_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RED,
		S_RD_CUR,
		S_WAIT_CUR,
		S_CAP_OLD,
		S_MUL1,
		S_WAIT_DIV,
		S_MUL3,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   fin_go;

	assign fin_go = !out_valid_q || out_ready;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nx      = S_RED;
				end
			end
			S_RED: begin
				cmd.reduce = 1'b1;
				state_nx   = S_RD_CUR;
			end
			S_RD_CUR: begin
				cmd.div_start = 1'b1;
				state_nx      = S_WAIT_CUR;
			end
			S_WAIT_CUR: begin
				cmd.cap_cur = 1'b1;
				cmd.rd_old  = 1'b1;
				state_nx    = (sts.op == OP_UPDATE) ? S_CAP_OLD : S_FIN;
			end
			S_CAP_OLD: begin
				cmd.cap_old = 1'b1;
				state_nx    = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_nx = S_WAIT_DIV;
			end
			S_WAIT_DIV: begin
				if (!sts.div_busy) begin
					cmd.tgt  = 1'b1;
					state_nx = S_MUL3;
				end
			end
			S_MUL3: begin
				cmd.mul3 = 1'b1;
				state_nx = S_FIN;
			end
			S_FIN: begin
				if (fin_go) begin
					cmd.fin  = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	`QLU_ASSERT_NEXT(a_accept_reduces, clk, arst_n, in_valid && in_ready, state_q == S_RED)
	`QLU_ASSERT_IMPL(a_result_from_fin, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_FIN)
	`QLU_ASSERT_NEXT(a_op_held, clk, arst_n, state_q != S_IDLE && state_q != S_CLEAR, $stable(sts.op))
endmodule

// ===== hw/rtl/tabular_q_learning_update_core.sv =====
// Tabular Q-learning core: epsilon-greedy choose, update and read on a Q8.8 table.
// Choose and read: reduce, table read and capture states, then the registered result.
// Update: the target step waits on the 10-step reward divider before the last multiply.
// Reset: async active low; a sweep over all STATES rows zeroes the table before in_ready rises.
// Depends on qlu_pkg, qlu_ctrl, qlu_dp (with qlu_ram and qlu_div).
module tabular_q_learning_update_core #(
	parameter int unsigned STATES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [1:0]         action,
	input  logic [9:0]         old_state,
	input  logic [9:0]         current_state,
	input  logic [9:0]         draw_explore,
	input  logic [9:0]         draw_first,
	input  logic [9:0]         draw_second,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         chosen_action,
	output logic               was_greedy,
	output logic signed [15:0] q_value,
	output logic               saturated
);
	import qlu_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	// Configuration registers. Write them only while the core is idle, so no
	// item ever sees a half-updated set. Unknown indexes drop silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learning_rate       <= RST_LEARNING_RATE;
			cfg_q.discount            <= RST_DISCOUNT;
			cfg_q.explore_thousandths <= RST_EXPLORE;
			cfg_q.major_reward        <= RST_MAJOR_REWARD;
			cfg_q.penalty             <= RST_PENALTY;
			cfg_q.positions           <= RST_POSITIONS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEARNING_RATE: cfg_q.learning_rate       <= cfg_data;
				CFG_DISCOUNT:      cfg_q.discount            <= cfg_data;
				CFG_EXPLORE:       cfg_q.explore_thousandths <= cfg_data[9:0];
				CFG_MAJOR_REWARD:  cfg_q.major_reward        <= cfg_data;
				CFG_PENALTY:       cfg_q.penalty             <= cfg_data;
				CFG_POSITIONS:     cfg_q.positions           <= cfg_data[10:0];
				default: begin
				end
			endcase
		end
	end

	// Controller: walks clear, read, multiply and writeback steps, and owns
	// the result valid so a new item can be taken while a result waits.
	qlu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: table RAM (one row of three values per state), reward
	// divider, and the alpha/gamma multiply chain with one rounding step.
	qlu_dp #(
		.STATES(STATES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.action        (action),
		.old_state     (old_state),
		.current_state (current_state),
		.draw_explore  (draw_explore),
		.draw_first    (draw_first),
		.draw_second   (draw_second),
		.chosen_action (chosen_action),
		.was_greedy    (was_greedy),
		.q_value       (q_value),
		.saturated     (saturated)
	);
endmodule
